>>> rtl/assert_macros.svh
// Assertion macros shared by the binary semaphore RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSFW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSFW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bsfw_pkg.sv
// Types, codes and defaults for the binary semaphore with waiter FIFO
`timescale 1ns / 1ps

package bsfw_pkg;

	localparam int MaxTasksDefault = 8;
	localparam int TaskIdW         = 3;

	typedef logic [TaskIdW-1:0] task_id_t;

	typedef enum logic [1:0] {
		CMD_TRY_TAKE  = 2'd0,
		CMD_TAKE      = 2'd1,
		CMD_GIVE_TASK = 2'd2,
		CMD_GIVE_ISR  = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_UNAVAIL = 2'd1,
		STS_BLOCKED = 2'd2,
		STS_DROPPED = 2'd3
	} status_e;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic rd_done;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;
	} dp_sts_t;

endpackage

>>> rtl/bsfw_req_if.sv
// Request channel: command, task id and task-present flag
`timescale 1ns / 1ps

interface bsfw_req_if;
	logic               valid;
	logic               ready;
	bsfw_pkg::cmd_e     cmd;
	bsfw_pkg::task_id_t task_id;
	logic               has_task;

	modport source (output valid, cmd, task_id, has_task, input ready);
	modport sink   (input valid, cmd, task_id, has_task, output ready);
endinterface

>>> rtl/bsfw_rsp_if.sv
// Response channel: status, wake report and scheduling hints
`timescale 1ns / 1ps

interface bsfw_rsp_if;
	logic                valid;
	logic                ready;
	bsfw_pkg::status_e   status;
	logic                woke_valid;
	bsfw_pkg::task_id_t  woke_id;
	logic                switch_request;
	logic                yield_giver;

	modport source (output valid, status, woke_valid, woke_id, switch_request, yield_giver,
		input ready);
	modport sink   (input valid, status, woke_valid, woke_id, switch_request, yield_giver,
		output ready);
endinterface

>>> rtl/bsfw_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module bsfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bsfw_dp.sv
// Datapath: available flag, waiter ring pointers and count, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsfw_dp #(
	parameter int MAX_TASKS = bsfw_pkg::MaxTasksDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsfw_pkg::cmd_e      cmd,
	input  bsfw_pkg::task_id_t  task_id,
	input  logic                has_task,
	input  bsfw_pkg::ctl_cmd_t  ctl,
	output bsfw_pkg::dp_sts_t   sts,
	output bsfw_pkg::status_e   status,
	output logic                woke_valid,
	output bsfw_pkg::task_id_t  woke_id,
	output logic                switch_request,
	output logic                yield_giver
);

	localparam int PtrW = $clog2(MAX_TASKS);
	localparam int CntW = $clog2(MAX_TASKS + 1);

	logic            avail_q;
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [CntW-1:0] count_q;

	logic               is_take;
	logic               is_give;
	logic               have_waiter;
	logic               full;
	logic               enqueue;
	logic               dequeue;
	bsfw_pkg::status_e  status_d;
	bsfw_pkg::task_id_t rd_data;

	bsfw_pkg::status_e  status_q;
	logic               woke_valid_q;
	bsfw_pkg::task_id_t woke_id_q;
	logic               sw_q;
	logic               yld_q;

	assign is_take     = (cmd == bsfw_pkg::CMD_TRY_TAKE) || (cmd == bsfw_pkg::CMD_TAKE);
	assign is_give     = !is_take;
	assign have_waiter = (count_q != '0);
	assign full        = (count_q == CntW'(MAX_TASKS));
	assign enqueue     = is_take && !avail_q && (cmd == bsfw_pkg::CMD_TAKE) && has_task && !full;
	assign dequeue     = is_give && have_waiter;

	assign sts.need_read = dequeue;

	always_comb begin
		status_d = bsfw_pkg::STS_OK;
		if (is_take && !avail_q) begin
			if ((cmd == bsfw_pkg::CMD_TRY_TAKE) || !has_task) begin
				status_d = bsfw_pkg::STS_UNAVAIL;
			end else if (full) begin
				status_d = bsfw_pkg::STS_DROPPED;
			end else begin
				status_d = bsfw_pkg::STS_BLOCKED;
			end
		end
	end

	bsfw_ram #(
		.WIDTH (bsfw_pkg::TaskIdW),
		.DEPTH (MAX_TASKS)
	) u_ring (
		.clk   (clk),
		.we    (ctl.accept && enqueue),
		.waddr (tail_q),
		.wdata (task_id),
		.re    (ctl.accept && dequeue),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.accept) begin
			if (is_take && avail_q) begin
				avail_q <= 1'b0;
			end else if (is_give && !have_waiter) begin
				avail_q <= 1'b1;
			end
			if (enqueue) begin
				tail_q  <= (tail_q == PtrW'(MAX_TASKS - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (dequeue) begin
				head_q  <= (head_q == PtrW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			status_q     <= status_d;
			woke_valid_q <= dequeue;
			woke_id_q    <= '0;
			sw_q         <= (status_d == bsfw_pkg::STS_BLOCKED) ||
				(status_d == bsfw_pkg::STS_DROPPED) ||
				(dequeue && (cmd == bsfw_pkg::CMD_GIVE_ISR));
			yld_q        <= dequeue && (cmd == bsfw_pkg::CMD_GIVE_TASK);
		end else if (ctl.rd_done) begin
			woke_id_q <= rd_data;
		end
	end

	assign status         = status_q;
	assign woke_valid     = woke_valid_q;
	assign woke_id        = woke_id_q;
	assign switch_request = sw_q;
	assign yield_giver    = yld_q;

	`BSFW_ASSERT_NOW(a_count_range, 1'b1, count_q <= CntW'(MAX_TASKS), "waiter count overflow")
	`BSFW_ASSERT_NOW(a_empty_ptrs, count_q == '0, head_q == tail_q, "empty ring with pointers apart")
	`BSFW_ASSERT_NEXT(a_read_follows, ctl.accept && dequeue, ctl.rd_done, "ring read not completed")

endmodule

>>> rtl/bsfw_ctrl.sv
// Controller: accept/read sequencing and response valid
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsfw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bsfw_pkg::dp_sts_t  sts,
	output bsfw_pkg::ctl_cmd_t ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign ctl.accept  = req_valid && req_ready;
	assign ctl.rd_done = (state_q == ST_READ);
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.accept) begin
						if (sts.need_read) begin
							state_q     <= ST_READ;
							rsp_valid_q <= 1'b0;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end else if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
				end
			endcase
		end
	end

	`BSFW_ASSERT_NOW(a_read_no_rsp, state_q == ST_READ, !rsp_valid_q, "response pending during read")
	`BSFW_ASSERT_NEXT(a_read_to_rsp, state_q == ST_READ, rsp_valid_q, "read without response")

endmodule

>>> rtl/binary_semaphore_fifo_waiters.sv
// Top level: binary semaphore with FIFO of waiting task ids
//
// channel | dir | payload
// req     | in  | cmd, task_id, has_task
// rsp     | out | status, woke_valid, woke_id, switch_request, yield_giver
//
// Takes and gives with no waiter: result valid in the cycle after the transfer.
// Give with a waiter: registered waiter RAM read, then ST_READ loads woke_id.
// One command in flight; a new request is taken while the response register drains.
// arst_n clears flag, pointers and count; no clearing pass (ring unread until written).
// A stalled response holds; requests stall until it is taken.
`timescale 1ns / 1ps

module binary_semaphore_fifo_waiters #(
	parameter int MAX_TASKS = bsfw_pkg::MaxTasksDefault
) (
	input logic       clk,
	input logic       arst_n,
	bsfw_req_if.sink  req,
	bsfw_rsp_if.source rsp
);

	bsfw_pkg::ctl_cmd_t ctl;
	bsfw_pkg::dp_sts_t  sts;

	bsfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	bsfw_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (req.cmd),
		.task_id        (req.task_id),
		.has_task       (req.has_task),
		.ctl            (ctl),
		.sts            (sts),
		.status         (rsp.status),
		.woke_valid     (rsp.woke_valid),
		.woke_id        (rsp.woke_id),
		.switch_request (rsp.switch_request),
		.yield_giver    (rsp.yield_giver)
	);

endmodule
